[hdl/queued_buffer_playback_cursor_top_assert.svh]
// Assertion macros for the playback cursor block.
// Expects clk and arst_n in the scope of every use.
`ifndef QUEUED_BUFFER_PLAYBACK_CURSOR_TOP_ASSERT_SVH
`define QUEUED_BUFFER_PLAYBACK_CURSOR_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define QBPC_ASSERT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);
// next-cycle implication
`define QBPC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);
`else
`define QBPC_ASSERT(name, pre, post, msg)
`define QBPC_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[hdl/qbpc_pkg.sv]
// Shared types and codes of the playback cursor block.
// No dependencies; used by the interfaces, the queue and the top level.
package qbpc_pkg;

	localparam int OP_W   = 3;
	localparam int LEN_W  = 24;
	localparam int ID_W   = 16;
	localparam int FRAC_W = 16;

	localparam logic [OP_W-1:0] OP_ADVANCE = 3'd0;
	localparam logic [OP_W-1:0] OP_SKIP    = 3'd1;
	localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd2;
	localparam logic [OP_W-1:0] OP_TAIL    = 3'd3;
	localparam logic [OP_W-1:0] OP_POP     = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [LEN_W-1:0] rate;
		logic [LEN_W-1:0] skip_frames;
		logic [ID_W-1:0]  buffer_id;
		logic [LEN_W-1:0] buffer_length;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]  sample_index;
		logic [LEN_W-1:0]  next_index;
		logic [FRAC_W-1:0] fraction;
		logic              at_end;
		logic              cross_buffer;
		logic              at_boundary;
		logic              queue_empty;
		logic [LEN_W-1:0]  remaining;
		logic              consumed_valid;
		logic [ID_W-1:0]   consumed_id;
		logic              empty_after_pop;
		logic              fire_ended;
	} res_t;

	// queue control from the cursor logic
	typedef struct packed {
		logic             pop;
		logic             push;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} q_ctl_t;

	// queue head view
	typedef struct packed {
		logic [ID_W-1:0]  head_id;
		logic [LEN_W-1:0] head_len;
		logic [LEN_W-1:0] next_len;
	} q_stat_t;

endpackage

[hdl/qbpc_cmd_if.sv]
// Command channel of the playback cursor: valid/ready plus one command item.
// Depends on qbpc_pkg.
interface qbpc_cmd_if;
	logic            valid;
	logic            ready;
	qbpc_pkg::cmd_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/qbpc_res_if.sv]
// Result channel of the playback cursor: valid/ready plus one result item.
// Depends on qbpc_pkg.
interface qbpc_res_if;
	logic            valid;
	logic            ready;
	qbpc_pkg::res_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/qbpc_queue.sv]
// Buffer queue of the playback cursor: shifting FIFO, head always in entry 0.
// Depends on qbpc_pkg and the assertion macro header.
`include "queued_buffer_playback_cursor_top_assert.svh"

module qbpc_queue #(
	parameter int QUEUE_DEPTH = 8,
	parameter int CNT_W       = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qbpc_pkg::q_ctl_t   ctl,
	output qbpc_pkg::q_stat_t  stat,
	output logic [CNT_W-1:0]   count
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);

	logic [qbpc_pkg::ID_W-1:0]  ids_q  [QUEUE_DEPTH];
	logic [qbpc_pkg::LEN_W-1:0] lens_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]           count_q;
	logic [SLOT_W-1:0]          wr_slot;

	// a push together with a pop is the tail append into an emptied queue
	assign wr_slot = ctl.pop ? '0 : count_q[SLOT_W-1:0];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
		localparam int                NXT  = (i + 1) % QUEUE_DEPTH;
		localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(i);

		always_ff @(posedge clk) begin
			if (ctl.push && wr_slot == SLOT) begin
				ids_q[i]  <= ctl.id;
				lens_q[i] <= ctl.len;
			end else if (ctl.pop) begin
				ids_q[i]  <= ids_q[NXT];
				lens_q[i] <= lens_q[NXT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case ({ctl.pop, ctl.push})
				2'b10:   count_q <= count_q - CNT_W'(1);
				2'b01:   count_q <= count_q + CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign stat.head_id  = ids_q[0];
	assign stat.head_len = lens_q[0];
	assign stat.next_len = lens_q[1];
	assign count         = count_q;

	`QBPC_ASSERT(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count past depth")
	`QBPC_ASSERT(a_pop_nonempty, ctl.pop, count_q != '0, "pop from empty queue")
	`QBPC_ASSERT(a_push_room, ctl.push && !ctl.pop, count_q < CNT_W'(QUEUE_DEPTH), "push into full queue")

endmodule

[hdl/queued_buffer_playback_cursor_top.sv]
// Playback cursor over a queue of audio buffers: input register, cursor
// logic, result register. Depends on qbpc_pkg, qbpc_cmd_if, qbpc_res_if,
// qbpc_queue and the assertion macro header.
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------
//  cmd      | in  | qbpc_pkg::cmd_t (one command)   | valid/ready
//  result   | out | qbpc_pkg::res_t (one per cmd)   | valid/ready
//
// One command per cycle while the result is not stalled; each result
// passes the input register, then the result register. Position add,
// saturation and the status compares on the new position sit in one stage.
// Reset clears position, queue count and pending tail; queue entries are not
// cleared. A stalled result blocks the input register, which still takes one
// more command while the result waits.
`include "queued_buffer_playback_cursor_top_assert.svh"

module queued_buffer_playback_cursor_top #(
	parameter int QUEUE_DEPTH = 8,
	parameter int INDEX_BITS  = 24,
	parameter int FRAC_BITS   = 16
) (
	input logic            clk,
	input logic            arst_n,
	qbpc_cmd_if.sink       cmd,
	qbpc_res_if.source     result
);

	localparam int LEN_W    = qbpc_pkg::LEN_W;
	localparam int POS_W    = INDEX_BITS + FRAC_BITS;
	localparam int LSH_W    = LEN_W + FRAC_BITS;
	localparam int ADD_W    = ((POS_W > LSH_W) ? POS_W : LSH_W) + 1;
	localparam int IDX_W    = ((INDEX_BITS + 1 > LEN_W) ? INDEX_BITS + 1 : LEN_W);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int FRAC_O_W = qbpc_pkg::FRAC_W;

	// pipeline registers
	logic            valid_s1;
	qbpc_pkg::cmd_t  cmd_s1;
	logic            valid_s2;
	qbpc_pkg::res_t  res_s2;

	// cursor state
	logic [POS_W-1:0] pos_q;
	logic             tail_pend_q;
	logic [LEN_W-1:0] tail_len_q;

	qbpc_pkg::q_ctl_t  q_ctl;
	qbpc_pkg::q_stat_t q_stat;
	logic [CNT_W-1:0]  q_count;

	logic             go;
	logic [2:0]       op;
	logic             has_q;
	logic             follow;
	logic [ADD_W-1:0] pos_ext;
	logic [ADD_W-1:0] step_ext;
	logic [ADD_W-1:0] sum;
	logic [POS_W-1:0] pos_sat;
	logic [ADD_W-1:0] head_sh;
	logic [POS_W-1:0] pos_rew;
	logic [INDEX_BITS-1:0] idx;
	logic [IDX_W-1:0] nxt;
	logic [FRAC_O_W+FRAC_BITS-1:0] frac_wide;

	logic [POS_W-1:0] pos_n;
	logic             tail_pend_n;
	logic [CNT_W-1:0] count_n;
	logic [LEN_W-1:0] head_len_n;
	logic [ADD_W-1:0] head_sh_n;
	logic [IDX_W-1:0] cur_n;
	logic [IDX_W-1:0] len_n_ext;
	qbpc_pkg::res_t   res_n;

	qbpc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.stat   (q_stat),
		.count  (q_count)
	);

	// handshake
	assign go            = valid_s1 && (!valid_s2 || result.ready);
	assign cmd.ready     = !valid_s1 || go;
	assign result.valid  = valid_s2;
	assign result.payload = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (go) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
		if (go) begin
			res_s2 <= res_n;
		end
	end

	// shared datapath
	assign op       = cmd_s1.operation;
	assign has_q    = q_count != '0;
	assign follow   = (q_count >= CNT_W'(2)) || tail_pend_q;
	assign pos_ext  = ADD_W'(pos_q);
	assign step_ext = (op == qbpc_pkg::OP_SKIP) ?
		(ADD_W'(cmd_s1.skip_frames) << FRAC_BITS) : ADD_W'(cmd_s1.rate);
	assign sum      = pos_ext + step_ext;
	assign pos_sat  = (|sum[ADD_W-1:POS_W]) ? {POS_W{1'b1}} : sum[POS_W-1:0];
	assign head_sh  = ADD_W'(q_stat.head_len) << FRAC_BITS;
	assign pos_rew  = (pos_ext >= head_sh) ? (pos_q - head_sh[POS_W-1:0]) : '0;
	assign idx      = pos_q[POS_W-1:FRAC_BITS];
	assign nxt      = IDX_W'(idx) + IDX_W'(1);
	// fraction moved to Q0.16: truncated or zero-filled as FRAC_BITS demands
	assign frac_wide = {pos_q[FRAC_BITS-1:0], {FRAC_O_W{1'b0}}};

	always_comb begin
		pos_n       = pos_q;
		tail_pend_n = tail_pend_q;
		q_ctl       = '0;
		res_n       = '0;

		// queue and cursor only move on a command that leaves the input register
		if (go) begin
			unique case (op)
				qbpc_pkg::OP_ADVANCE: begin
					if (!has_q) begin
						res_n.at_end = 1'b1;
					end else begin
						pos_n              = pos_sat;
						res_n.sample_index = LEN_W'(idx);
						res_n.fraction     = frac_wide[FRAC_BITS+FRAC_O_W-1:FRAC_BITS];
						res_n.next_index   = LEN_W'(nxt);
						if (nxt >= IDX_W'(q_stat.head_len)) begin
							if (follow) begin
								res_n.next_index   = '0;
								res_n.cross_buffer = 1'b1;
							end else begin
								res_n.next_index = LEN_W'(idx);
								res_n.at_end     = sum >= head_sh;
							end
						end
					end
				end
				qbpc_pkg::OP_SKIP: begin
					pos_n = pos_sat;
				end
				qbpc_pkg::OP_ENQUEUE: begin
					// full queue drops the buffer
					q_ctl.push = q_count < CNT_W'(QUEUE_DEPTH);
					q_ctl.id   = cmd_s1.buffer_id;
					q_ctl.len  = cmd_s1.buffer_length;
				end
				qbpc_pkg::OP_TAIL: begin
					tail_pend_n = 1'b1;
				end
				qbpc_pkg::OP_POP: begin
					if (has_q) begin
						q_ctl.pop             = 1'b1;
						pos_n                 = pos_rew;
						res_n.consumed_valid  = 1'b1;
						res_n.consumed_id     = q_stat.head_id;
						res_n.empty_after_pop = q_count == CNT_W'(1);
						// tail goes in under the popped id when the pop empties the queue
						q_ctl.push            = res_n.empty_after_pop && tail_pend_q;
						q_ctl.id              = q_stat.head_id;
						q_ctl.len             = tail_len_q;
						res_n.fire_ended      = !q_ctl.push;
						if (q_ctl.push) begin
							tail_pend_n = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// status on the state after this command
		unique case ({q_ctl.pop, q_ctl.push})
			2'b10:   count_n = q_count - CNT_W'(1);
			2'b01:   count_n = q_count + CNT_W'(1);
			default: count_n = q_count;
		endcase

		if (q_ctl.push && (q_ctl.pop || !has_q)) begin
			head_len_n = q_ctl.len;
		end else if (q_ctl.pop) begin
			head_len_n = q_stat.next_len;
		end else begin
			head_len_n = q_stat.head_len;
		end

		head_sh_n = ADD_W'(head_len_n) << FRAC_BITS;
		cur_n     = IDX_W'(pos_n[POS_W-1:FRAC_BITS]);
		len_n_ext = IDX_W'(head_len_n);

		if (count_n == '0) begin
			res_n.at_boundary = 1'b1;
			res_n.queue_empty = 1'b1;
			res_n.remaining   = '0;
		end else begin
			res_n.at_boundary = ADD_W'(pos_n) >= head_sh_n;
			res_n.queue_empty = 1'b0;
			res_n.remaining   = (cur_n < len_n_ext) ? LEN_W'(len_n_ext - cur_n) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			tail_pend_q <= 1'b0;
		end else if (go) begin
			pos_q       <= pos_n;
			tail_pend_q <= tail_pend_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go && op == qbpc_pkg::OP_TAIL) begin
			tail_len_q <= cmd_s1.buffer_length;
		end
	end

	`QBPC_ASSERT_NEXT(a_idle_no_advance, go && op != qbpc_pkg::OP_ADVANCE, res_s2.sample_index == '0 && !res_s2.cross_buffer, "advance fields set on other command")
	`QBPC_ASSERT_NEXT(a_pop_reports, go && op == qbpc_pkg::OP_POP && has_q, res_s2.consumed_valid, "pop not reported")
	`QBPC_ASSERT_NEXT(a_result_loaded, go, valid_s2, "result register lost a result")
	`QBPC_ASSERT(a_queue_gated, !go, !q_ctl.push && !q_ctl.pop, "queue moved without a transfer")

endmodule
